@@ src/sti_pkg.sv @@
package sti_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;
   localparam int POS_W   = 4;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   typedef struct packed {
      logic                      action;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   position;
      status_type         status;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

@@ src/sti_stream_if.sv @@
interface sti_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/sti_controller.sv @@
module sti_controller import sti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_UPDATE) && !req_ready)
      else $error("accepted beat did not move to update");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("commit did not present a result");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("stalled result beat dropped");

endmodule

@@ src/sti_datapath.sv @@
module sti_datapath import sti_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int CW = $clog2(DEPTH + 1),
   localparam int IW = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   logic signed [VALUE_W-1:0] store_ff [DEPTH];
   logic signed [VALUE_W-1:0] store_in [DEPTH];
   logic signed [VALUE_W-1:0] store_dn [DEPTH];
   logic signed [VALUE_W-1:0] store_up [DEPTH];
   logic [CW-1:0]             count_ff, count_in;
   logic                      action_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [DEPTH-1:0]          le_ff, le_in, lt_ff, lt_in, eq_ff, eq_in;
   logic [DEPTH-1:0]          le_prev, lt_prev, ins_hot, del_hot;
   logic [IW-1:0]             ins_pos, del_pos, pos;
   logic                      full, found, ins_ok, del_ok;
   rsp_payload_type           rsp_ff, rsp_in;

   // per cell compare against the incoming value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le_in[i] = (CW'(i) < count_ff) && (store_ff[i] <= req_payload.value);
         lt_in[i] = (CW'(i) < count_ff) && (store_ff[i] <  req_payload.value);
         eq_in[i] = (CW'(i) < count_ff) && (store_ff[i] == req_payload.value);
      end
   end

   assign le_prev = {le_ff[DEPTH-2:0], 1'b1};
   assign lt_prev = {lt_ff[DEPTH-2:0], 1'b1};
   assign ins_hot = le_prev & ~le_ff;
   assign del_hot = lt_prev & ~lt_ff & eq_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
      if (g == 0) begin : g_first
         assign store_dn[g] = value_ff;
      end else begin : g_rest
         assign store_dn[g] = store_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign store_up[g] = store_ff[g];
      end else begin : g_body
         assign store_up[g] = store_ff[g+1];
      end
   end

   assign full   = (count_ff == CW'(DEPTH));
   assign found  = |del_hot;
   assign ins_ok = (action_ff == ACT_INSERT) && !full;
   assign del_ok = (action_ff == ACT_DELETE) && found;

   // one-hot boundary to index
   always_comb begin
      ins_pos = '0;
      del_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ins_pos = ins_pos | (ins_hot[i] ? IW'(i) : '0);
         del_pos = del_pos | (del_hot[i] ? IW'(i) : '0);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (ins_ok && !le_ff[i]) begin
            store_in[i] = le_prev[i] ? value_ff : store_dn[i];
         end else if (del_ok && !lt_ff[i]) begin
            store_in[i] = store_up[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      pos      = '0;
      if (ins_ok) begin
         count_in = count_ff + CW'(1);
         pos      = ins_pos;
      end else if (del_ok) begin
         count_in = count_ff - CW'(1);
         pos      = del_pos;
      end
      rsp_in.count    = COUNT_W'({{COUNT_W{1'b0}}, count_in});
      rsp_in.position = POS_W'({{POS_W{1'b0}}, pos});
      if (ins_ok || del_ok) begin
         rsp_in.status = ST_DONE;
      end else if (action_ff == ACT_INSERT) begin
         rsp_in.status = ST_FULL;
      end else begin
         rsp_in.status = ST_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_payload.action;
         value_ff  <= req_payload.value;
         le_ff     <= le_in;
         lt_ff     <= lt_in;
         eq_ff     <= eq_in;
      end
      if (cmd.commit) begin
         store_ff <= store_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_flags_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> ((le_ff & (le_ff + DEPTH'(1))) == '0) && ((lt_ff & ~le_ff) == '0))
      else $error("compare flags not a sorted prefix");

   a_one_position: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(del_hot) && (full || $onehot(ins_hot)))
      else $error("position boundary not unique");

endmodule

@@ src/sorted_table_insert_delete.sv @@
// an accepted request is captured with its compare flags across the cell row,
// then the commit shifts the row and registers the result; no new request is
// taken until the commit, and a stalled result beat holds the commit back
// reset: synchronous, clears the entry count and both handshakes
// stored values are not cleared, entries at or above the count are never used
module sorted_table_insert_delete import sti_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic reset,
   sti_stream_if.sink   req_chan,
   sti_stream_if.source rsp_chan
);

   cmd_type cmd;

   sti_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   sti_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

@@ tb/sv/sorted_table_insert_delete_tb.sv @@
`timescale 1ns / 100ps

module sorted_table_insert_delete_tb;
   import sti_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int RAND_ITEMS  = 430;
   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 2000;
   localparam int DIR_ROWS    = 25;

   typedef struct {
      logic                      act;
      logic signed [VALUE_W-1:0] val;
      bit                        fixed;
      logic [COUNT_W-1:0]        cnt;
      logic [POS_W-1:0]          pos;
      status_type                st;
   } op_row_type;

   logic clock;
   logic reset;

   sti_stream_if #(.payload_type(req_payload_type)) req_if ();
   sti_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   sorted_table_insert_delete #(.DEPTH(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow copy of the sorted store
   logic signed [VALUE_W-1:0] table_vals [TABLE_DEPTH];
   int                        table_count;
   rsp_payload_type           rsp_q [$];

   int  fail_count;
   int  n_insert, n_delete, n_full, n_absent, n_results;
   bit  steady;
   bit  rsp_hold_request;

   op_row_type dir_rows [DIR_ROWS] = '{
      '{ACT_DELETE, 32'sd5,           1'b1, 5'd0,  4'd0,  ST_NOT_FOUND},
      '{ACT_INSERT, 32'sd0,           1'b1, 5'd1,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sh7FFFFFFF,    1'b1, 5'd2,  4'd1,  ST_DONE},
      '{ACT_INSERT, 32'sh80000000,    1'b1, 5'd3,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd0,           1'b1, 5'd4,  4'd2,  ST_DONE},
      '{ACT_INSERT, -32'sd1,          1'b1, 5'd5,  4'd1,  ST_DONE},
      '{ACT_DELETE, 32'sd0,           1'b1, 5'd4,  4'd2,  ST_DONE},
      '{ACT_DELETE, 32'sd12345,       1'b1, 5'd4,  4'd0,  ST_NOT_FOUND},
      '{ACT_INSERT, 32'sd7,           1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd7,           1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, -32'sd7,          1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd100,         1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, -32'sd100,        1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sh55555555,    1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'shAAAAAAAA,    1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd1,           1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd2,           1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, -32'sd2,          1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd7,           1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sh40000000,    1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, 32'sd3,           1'b1, 5'd16, 4'd0,  ST_FULL},
      '{ACT_DELETE, 32'sh7FFFFFFF,    1'b1, 5'd15, 4'd15, ST_DONE},
      '{ACT_DELETE, 32'sh80000000,    1'b1, 5'd14, 4'd0,  ST_DONE},
      '{ACT_DELETE, 32'sd7,           1'b0, 5'd0,  4'd0,  ST_DONE},
      '{ACT_INSERT, -32'sd1,          1'b0, 5'd0,  4'd0,  ST_DONE}
   };

   function automatic rsp_payload_type table_apply(input logic act,
                                                   input logic signed [VALUE_W-1:0] val);
      rsp_payload_type r;
      int              slot;
      bit              found;
      slot  = 0;
      found = 1'b0;
      r.status = ST_DONE;
      if (act == ACT_INSERT) begin
         n_insert++;
         if (table_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
            n_full++;
         end else begin
            for (int i = 0; i < table_count; i++)
               if (table_vals[i] <= val) slot = i + 1;
            for (int i = table_count; i > slot; i--)
               table_vals[i] = table_vals[i-1];
            table_vals[slot] = val;
            table_count++;
         end
      end else begin
         n_delete++;
         for (int i = 0; i < table_count; i++) begin
            if (!found && table_vals[i] == val) begin
               slot  = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            slot     = 0;
            r.status = ST_NOT_FOUND;
            n_absent++;
         end else begin
            for (int i = slot; i + 1 < table_count; i++)
               table_vals[i] = table_vals[i+1];
            table_count--;
         end
      end
      r.count    = COUNT_W'(table_count);
      r.position = POS_W'(slot);
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return VALUE_W'(int'($urandom_range(0, 16)) - 8);
      if (sel == 4) begin
         case ($urandom_range(0, 3))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_op(input logic act, input logic signed [VALUE_W-1:0] val,
                          input bit fixed, input rsp_payload_type fixed_rsp);
      rsp_payload_type predicted;
      req_if.valid   <= 1'b1;
      req_if.payload <= '{action: act, value: val};
      do @(posedge clock); while (!req_if.ready);
      predicted = table_apply(act, val);
      rsp_q.push_back(fixed ? fixed_rsp : predicted);
   endtask

   task automatic sender_gap();
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold the request side until every result is back
   task automatic drain_pause();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (rsp_q.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request side
   initial begin
      logic                      act;
      logic signed [VALUE_W-1:0] val;
      bit                        filling;
      rsp_payload_type           fixed_rsp;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      table_count    = 0;
      fail_count     = 0;
      steady         = 1'b0;
      filling        = 1'b1;
      rsp_hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         fixed_rsp.count    = dir_rows[k].cnt;
         fixed_rsp.position = dir_rows[k].pos;
         fixed_rsp.status   = dir_rows[k].st;
         send_op(dir_rows[k].act, dir_rows[k].val, dir_rows[k].fixed, fixed_rsp);
         sender_gap();
      end
      drain_pause();

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == 120) steady = 1'b1;
         if (n == 220) steady = 1'b0;
         if (n == 300) rsp_hold_request = 1'b1;
         if (n == 160 || n == 380) drain_pause();
         if (table_count == TABLE_DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
         if (table_count == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
         act = (filling ^ ($urandom_range(0, 99) < 20)) ? ACT_INSERT : ACT_DELETE;
         if (act == ACT_DELETE && table_count > 0 && $urandom_range(0, 99) < 80)
            val = table_vals[$urandom_range(0, table_count - 1)];
         else
            val = pick_value();
         send_op(act, val, 1'b0, '0);
         sender_gap();
      end

      drain_pause();
      repeat (10) @(posedge clock);
      $display("covered %0d inserts (%0d refused full), %0d deletes (%0d value missing)",
               n_insert, n_full, n_delete, n_absent);
      $display("%0d result beats checked, store depth %0d", n_results, TABLE_DEPTH);
      if (fail_count == 0) begin
         $display("[sorted_table_insert_delete] OK");
      end else begin
         $display("[sorted_table_insert_delete] ERROR");
      end
      $finish;
   end

   // result side
   initial begin
      rsp_payload_type want;
      int              hold_left;
      hold_left    = 0;
      n_results    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (rsp_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = rsp_q.pop_front();
               if (rsp_if.payload.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_if.payload.count);
                  fail_count++;
               end
               if (rsp_if.payload.position !== want.position) begin
                  $error("position: expected %0d, got %0d",
                         want.position, rsp_if.payload.position);
                  fail_count++;
               end
               if (rsp_if.payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.payload.status);
                  fail_count++;
               end
            end
         end
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // watchdog
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     quiet, rsp_q.size());
            $display("[sorted_table_insert_delete] ERROR");
            $finish;
         end
      end
   end

endmodule
